### rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`endif

### rtl/bnfa_pkg.sv
`timescale 1ns / 1ps
package bnfa_pkg;
	localparam int MAX_SIDE = 16;
	localparam int POOL_UNITS = 1024;
	localparam int MAX_ITEM = 64;
	localparam int HANDLES = MAX_SIDE * MAX_SIDE;
	localparam int UW = $clog2(POOL_UNITS);
	localparam int HW = $clog2(HANDLES);
	localparam int SW = 7;
	localparam int CFG_W = 7;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_SIZE = 3'd1;
	localparam logic [2:0] ST_ROOM = 3'd2;
	localparam logic [2:0] ST_EMPTY = 3'd3;
	localparam logic [2:0] ST_GRID = 3'd4;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE = 2'd1;

	localparam logic [1:0] CFG_SIDE = 2'd0;
	localparam logic [1:0] CFG_LIMIT = 2'd1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] cell_row;
		logic [3:0] cell_col;
		logic [6:0] alloc_size;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [9:0] start_unit;
		logic [6:0] run_size;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLR, S_CHK, S_HRD, S_REL, S_SCAN, S_MARK, S_HINT, S_RESTORE, S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture request
		logic clr_step;   // clear one map unit / handle
		logic hrd;        // read handle entry
		logic rel_step;   // clear one unit of old run
		logic scan_step;  // examine one unit
		logic mark_step;  // set one unit of new run
		logic hint_step;  // examine one unit for hint
		logic rest_step;  // set one unit of old run
		logic wr_handle;  // write new run to handle
		logic clr_handle; // empty handle
		logic cnt_rst;    // reset counters
		logic fin;        // emit result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic grid_bad;
		logic size_bad;
		logic is_alloc;
		logic is_free;
		logic empty;
		logic run_last;   // last unit of current run walk
		logic found;      // scan found a fitting run
		logic scan_fail;  // all starts tried
		logic hint_done;
	} sts_t;
endpackage

### rtl/bnfa_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bnfa_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  bnfa_pkg::sts_t sts,
	output bnfa_pkg::cmd_t cmd
);
	import bnfa_pkg::*;
	state_t state_q, nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= nxt;
	end

	always_comb begin
		nxt = state_q;
		case (state_q)
			S_CLR: if (sts.clr_last) nxt = S_IDLE;
			S_IDLE: if (start) nxt = S_CHK;
			S_CHK: begin
				if (sts.grid_bad || (sts.is_alloc && sts.size_bad)) nxt = S_DONE;
				else nxt = S_HRD;
			end
			S_HRD: begin
				if (sts.is_alloc) nxt = sts.empty ? S_SCAN : S_REL;
				else if (sts.empty || !sts.is_free) nxt = S_DONE;
				else nxt = S_REL;
			end
			S_REL: if (sts.run_last) nxt = sts.is_alloc ? S_SCAN : S_DONE;
			S_SCAN: begin
				if (sts.found) nxt = S_MARK;
				else if (sts.scan_fail) nxt = sts.empty ? S_DONE : S_RESTORE;
			end
			S_MARK: if (sts.run_last) nxt = S_HINT;
			S_HINT: if (sts.hint_done) nxt = S_DONE;
			S_RESTORE: if (sts.run_last) nxt = S_DONE;
			S_DONE: nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_CLR: cmd.clr_step = 1'b1;
			S_IDLE: cmd.load = start;
			S_CHK: cmd.hrd = 1'b1;
			S_HRD: cmd.cnt_rst = 1'b1;
			S_REL: begin
				cmd.rel_step = 1'b1;
				if (sts.run_last) begin
					cmd.cnt_rst = 1'b1;
					cmd.clr_handle = !sts.is_alloc;
				end
			end
			S_SCAN: begin
				cmd.scan_step = !sts.found;
				if (sts.found || sts.scan_fail) cmd.cnt_rst = 1'b1;
			end
			S_MARK: begin
				cmd.mark_step = 1'b1;
				if (sts.run_last) begin
					cmd.cnt_rst = 1'b1;
					cmd.wr_handle = 1'b1;
				end
			end
			S_HINT: cmd.hint_step = 1'b1;
			S_RESTORE: cmd.rest_step = 1'b1;
			S_DONE: cmd.fin = 1'b1;
			default: ;
		endcase
	end

	`ASSERT_NEVER(a_no_accept_busy, cmd.load && busy, "load while busy")
	`ASSERT_CLK(a_fin_idle, cmd.fin |=> !busy, "no idle after result")
	`ASSERT_NEVER(a_one_walk, $countones({cmd.rel_step, cmd.mark_step, cmd.rest_step,
		cmd.scan_step, cmd.hint_step, cmd.clr_step}) > 1, "two walks at once")
endmodule

### rtl/bnfa_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bnfa_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [bnfa_pkg::CFG_W-1:0] cfg_data,
	input  bnfa_pkg::req_t req,
	input  bnfa_pkg::cmd_t cmd,
	output bnfa_pkg::sts_t sts,
	output logic done,
	output bnfa_pkg::rsp_t rsp
);
	import bnfa_pkg::*;
	logic map_q [POOL_UNITS];
	logic [UW-1:0] hs_mem [HANDLES];
	logic [SW-1:0] hn_mem [HANDLES];
	logic [4:0] side_q;
	logic [6:0] limit_q;
	req_t req_q;
	logic [UW-1:0] hint_q, old_s_q, base_q, new_s_q;
	logic [SW-1:0] old_n_q;
	logic [UW:0] cnt_q;   // walk counter
	logic [UW:0] tries_q; // starts tried
	logic [SW-1:0] run_q; // free run length
	logic [HW-1:0] h_q;
	logic [2:0] st_q;
	logic done_q;
	logic [4:0] side_c;
	logic [6:0] lim_c;
	logic [HW:0] hcalc;
	logic [UW-1:0] unit;
	logic map_rd_q;   // registered map read of unit
	logic ph_q;       // scan/hint walk: 0 read issued, 1 read data ready
	logic scan_eval;
	logic hint_eval;
	logic grid_bad;
	logic hint_hit_q;
	logic [UW:0] pos; // base + run length for scan

	assign side_c = (side_q > 5'(MAX_SIDE)) ? 5'(MAX_SIDE) : side_q;
	assign lim_c = (limit_q > 7'(MAX_ITEM)) ? 7'(MAX_ITEM) : limit_q;
	assign hcalc = (HW+1)'(req_q.cell_row) * (HW+1)'(side_c) + (HW+1)'(req_q.cell_col);
	assign grid_bad = ({1'b0, req_q.cell_row} >= side_c) || ({1'b0, req_q.cell_col} >= side_c);
	assign scan_eval = cmd.scan_step && ph_q;
	assign hint_eval = cmd.hint_step && ph_q;

	// address of the unit touched this cycle
	always_comb begin
		pos = {1'b0, base_q} + (UW+1)'(run_q);
		if (cmd.scan_step) unit = pos[UW-1:0];
		else if (cmd.clr_step) unit = cnt_q[UW-1:0];
		else if (cmd.rel_step || cmd.rest_step) unit = old_s_q + cnt_q[UW-1:0];
		else if (cmd.mark_step) unit = base_q + cnt_q[UW-1:0];
		else unit = hint_q + cnt_q[UW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step || cmd.rel_step) map_q[unit] <= 1'b0;
		else if (cmd.mark_step || cmd.rest_step) map_q[unit] <= 1'b1;
		map_rd_q <= map_q[unit];
		if (cmd.clr_step && (cnt_q < (UW+1)'(HANDLES))) begin
			hs_mem[cnt_q[HW-1:0]] <= '0;
			hn_mem[cnt_q[HW-1:0]] <= '0;
		end else if (cmd.wr_handle) begin
			hs_mem[h_q] <= base_q;
			hn_mem[h_q] <= req_q.alloc_size;
		end else if (cmd.clr_handle) begin
			hs_mem[h_q] <= '0;
			hn_mem[h_q] <= '0;
		end
		if (cmd.hrd) begin
			old_s_q <= hs_mem[hcalc[HW-1:0]];
			old_n_q <= hn_mem[hcalc[HW-1:0]];
		end
		if (cmd.load) req_q <= req;
		if (cmd.hrd) h_q <= hcalc[HW-1:0];
	end

	logic cur_last;
	assign cur_last = cmd.mark_step ? (cnt_q == (UW+1)'(req_q.alloc_size) - 1'b1)
	                                : (cnt_q == (UW+1)'(old_n_q) - 1'b1);
	logic fits;
	assign fits = (run_q == req_q.alloc_size);
	logic edge_bad; // run would pass pool end
	assign edge_bad = pos[UW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= 5'd16; limit_q <= 7'd64; hint_q <= '0;
			cnt_q <= '0; tries_q <= '0; run_q <= '0; base_q <= '0;
			st_q <= ST_OK; done_q <= 1'b0; new_s_q <= '0; ph_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
			if (cfg_we) begin
				if (cfg_idx == CFG_SIDE) side_q <= cfg_data[4:0];
				else if (cfg_idx == CFG_LIMIT) limit_q <= cfg_data;
			end
			if (cmd.scan_step || cmd.hint_step) ph_q <= !ph_q;
			else ph_q <= 1'b0;
			if (cmd.cnt_rst) cnt_q <= '0;
			else if (cmd.clr_step || cmd.rel_step || cmd.mark_step || cmd.rest_step ||
			         hint_eval) cnt_q <= cnt_q + 1'b1;
			if (cmd.load) begin
				base_q <= hint_q; run_q <= '0; tries_q <= '0;
			end else if (scan_eval) begin
				if (edge_bad || map_rd_q) begin
					// advance start
					run_q <= '0;
					tries_q <= tries_q + 1'b1;
					base_q <= base_q + 1'b1;
				end else run_q <= run_q + 1'b1;
			end
			if (cmd.hrd) begin
				if (grid_bad) st_q <= ST_GRID;
				else if (req_q.req_type == REQ_ALLOC &&
				         (req_q.alloc_size == '0 || req_q.alloc_size > lim_c))
					st_q <= ST_SIZE;
				else st_q <= ST_OK;
			end else if (sts.scan_fail) st_q <= ST_ROOM;
			if (sts.found) new_s_q <= base_q;
			if (hint_eval && !map_rd_q && !hint_hit_q) hint_q <= unit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hint_hit_q <= 1'b0;
		else if (cmd.cnt_rst) hint_hit_q <= 1'b0;
		else if (hint_eval && !map_rd_q) hint_hit_q <= 1'b1;
	end

	assign sts.clr_last = (cnt_q == (UW+1)'(POOL_UNITS - 1));
	assign sts.grid_bad = grid_bad;
	assign sts.size_bad = (req_q.alloc_size == '0) || (req_q.alloc_size > lim_c);
	assign sts.is_alloc = (req_q.req_type == REQ_ALLOC);
	assign sts.is_free = (req_q.req_type == REQ_FREE);
	assign sts.empty = (old_n_q == '0);
	assign sts.run_last = cur_last;
	assign sts.found = fits;
	assign sts.scan_fail = !fits && (tries_q == (UW+1)'(POOL_UNITS));
	assign sts.hint_done = hint_hit_q ||
	                       (hint_eval && (!map_rd_q || (cnt_q == (UW+1)'(POOL_UNITS - 1))));

	assign done = done_q;
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (st_q == ST_OK && !sts.is_alloc && sts.empty) begin
				rsp.status <= ST_EMPTY; rsp.start_unit <= '0; rsp.run_size <= '0;
			end else if (st_q != ST_OK) begin
				rsp.status <= st_q; rsp.start_unit <= '0; rsp.run_size <= '0;
			end else if (sts.is_alloc) begin
				rsp.status <= st_q; rsp.start_unit <= new_s_q; rsp.run_size <= req_q.alloc_size;
			end else begin
				rsp.status <= st_q; rsp.start_unit <= old_s_q; rsp.run_size <= old_n_q;
			end
		end
	end

	`ASSERT_CLK(a_found_fits, sts.found |-> (pos <= (UW+1)'(POOL_UNITS)), "run crosses pool end")
	`ASSERT_NEVER(a_run_cap, run_q > req_q.alloc_size && cmd.scan_step, "run overshoot")
	`ASSERT_CLK(a_done_pulse, done |=> !done, "result held two cycles")
endmodule

### rtl/bitmap_next_fit_allocator_unit.sv
`timescale 1ns / 1ps
// Bitmap next-fit run allocator.
// Request channel: drive req and pulse start; an item is taken on a clock edge
// with start high and busy low. busy drops in the cycle the result is shown.
// Result channel: done is high for one cycle with rsp valid; the receiver
// cannot stall, so results must be taken when shown.
// Config: cfg_we/cfg_idx/cfg_data write grid_side (0) or item_limit (1) while
// idle; other indexes are dropped; no wait, no read-back.
// Sequence: lookup and empty free pass the check and handle-read states, then
// show the result; grid and size failures skip the handle read. Free adds a
// walk over the units of the released run. Allocate adds old-run release, the
// bitmap scan, marking of the new run's units and the hint walk. The use map is
// read through a register, so scan and hint walk issue a read and then evaluate
// its data for each unit examined; when nothing fits, the old run is restored.
// The hint walk goes from the hint over used units up to the first free one.
// Reset: after arst_n releases, a clearing pass over all POOL_UNITS (1024) map
// units empties the map and handle table; busy is high during it.
module bitmap_next_fit_allocator_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  bnfa_pkg::req_t req,
	output logic done,
	output bnfa_pkg::rsp_t rsp,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [bnfa_pkg::CFG_W-1:0] cfg_data
);
	import bnfa_pkg::*;
	cmd_t cmd;
	sts_t sts;

	bnfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);
	bnfa_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .req(req), .cmd(cmd), .sts(sts), .done(done), .rsp(rsp)
	);
endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import bnfa_pkg::*;

	localparam logic [1:0] REQ_LOOKUP = 2'd2;
	localparam logic [1:0] REQ_ODD = 2'd3;      // undefined code, acts as lookup
	localparam logic [1:0] CFG_SPARE = 2'd2;    // unmapped register index
	localparam int STALL_LIMIT = 600000;        // covers the clearing pass and a full-pool alloc
	localparam int TAIL_CYCLES = 20;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	bitmap_next_fit_allocator_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// shadow copy of the allocator state
	bit unit_used [POOL_UNITS];
	logic [9:0] run_start [HANDLES];
	logic [6:0] run_len [HANDLES];
	logic [9:0] next_hint;
	logic [4:0] side_reg;
	logic [6:0] limit_reg;

	req_t pending_items[$];
	rsp_t expected_rsps[$];
	int errors;
	int gap;
	int stall_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit span_free(int s, int n);
		if (s + n > POOL_UNITS) return 0;
		for (int k = 0; k < n; k++)
			if (unit_used[s + k]) return 0;
		return 1;
	endfunction

	function automatic void mark_span(int s, int n, bit v);
		for (int k = 0; k < n; k++)
			if (s + k < POOL_UNITS) unit_used[s + k] = v;
	endfunction

	// expected response for one request; updates the shadow state
	function automatic rsp_t allocator_response(req_t r);
		rsp_t o;
		int side;
		int lim;
		int h;
		int s;
		int u;
		side = (side_reg > MAX_SIDE) ? MAX_SIDE : side_reg;
		lim = (limit_reg > MAX_ITEM) ? MAX_ITEM : limit_reg;
		o = '0;
		if (r.cell_row >= side || r.cell_col >= side) begin
			o.status = ST_GRID;
			return o;
		end
		h = r.cell_row * side + r.cell_col;
		if (r.req_type == REQ_ALLOC) begin
			if (r.alloc_size == 0 || r.alloc_size > lim) begin
				o.status = ST_SIZE;
				return o;
			end
			if (run_len[h] != 0) mark_span(int'(run_start[h]), int'(run_len[h]), 1'b0);
			for (int k = 0; k < POOL_UNITS; k++) begin
				s = (next_hint + k) % POOL_UNITS;
				if (span_free(s, int'(r.alloc_size))) begin
					mark_span(s, int'(r.alloc_size), 1'b1);
					run_start[h] = 10'(s);
					run_len[h] = r.alloc_size;
					for (int j = 0; j < POOL_UNITS; j++) begin
						u = (next_hint + j) % POOL_UNITS;
						if (!unit_used[u]) begin
							next_hint = 10'(u);
							break;
						end
					end
					o.status = ST_OK;
					o.start_unit = 10'(s);
					o.run_size = r.alloc_size;
					return o;
				end
			end
			// nothing fits: old run stays put
			if (run_len[h] != 0) mark_span(int'(run_start[h]), int'(run_len[h]), 1'b1);
			o.status = ST_ROOM;
			return o;
		end
		if (run_len[h] == 0) begin
			o.status = ST_EMPTY;
			return o;
		end
		o.status = ST_OK;
		o.start_unit = run_start[h];
		o.run_size = run_len[h];
		if (r.req_type == REQ_FREE) begin
			mark_span(int'(run_start[h]), int'(run_len[h]), 1'b0);
			run_start[h] = '0;
			run_len[h] = '0;
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, rsp_t got, rsp_t want);
		$display("MISMATCH %s: got st=%0d start=%0d size=%0d, want st=%0d start=%0d size=%0d",
			what, got.status, got.start_unit, got.run_size,
			want.status, want.start_unit, want.run_size);
		errors++;
	endtask

	// driver: holds start until the item is taken, random gaps between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			gap <= 0;
		end else if (start && !busy) begin
			expected_rsps.push_back(allocator_response(req));
			if (pending_items.size() != 0 && $urandom_range(0, 3) == 0) begin
				req <= pending_items.pop_front();
			end else begin
				start <= 1'b0;
				gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
					: $urandom_range(0, 4);
			end
		end else if (!start) begin
			if (gap > 0) begin
				gap <= gap - 1;
			end else if (pending_items.size() != 0) begin
				start <= 1'b1;
				req <= pending_items.pop_front();
			end
		end
	end

	// monitor: every done pulse is matched against the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				report_mismatch("unexpected result", rsp, '0);
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.status !== want.status) report_mismatch("status", rsp, want);
				else if (rsp.start_unit !== want.start_unit) report_mismatch("start", rsp, want);
				else if (rsp.run_size !== want.run_size) report_mismatch("size", rsp, want);
			end
		end
	end

	// watchdog: no item taken and no result for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic cfg_write(logic [1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		if (idx == CFG_SIDE) side_reg = val[4:0];
		else if (idx == CFG_LIMIT) limit_reg = val;
	endtask

	task automatic cfg_finish();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_quiet();
		while (pending_items.size() != 0 || start || expected_rsps.size() != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void queue_item(logic [1:0] t, int row, int col, int n);
		req_t r;
		r.req_type = t;
		r.cell_row = 4'(row);
		r.cell_col = 4'(col);
		r.alloc_size = 7'(n);
		pending_items.push_back(r);
	endfunction

	function automatic void queue_random(int count);
		int side;
		int lim;
		int pick;
		int row;
		int col;
		int n;
		logic [1:0] t;
		side = (side_reg > MAX_SIDE) ? MAX_SIDE : side_reg;
		lim = (limit_reg > MAX_ITEM) ? MAX_ITEM : limit_reg;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			t = (pick < 50) ? REQ_ALLOC : (pick < 75) ? REQ_FREE
				: (pick < 95) ? REQ_LOOKUP : REQ_ODD;
			if (side == 0 || $urandom_range(0, 19) == 0) begin
				row = $urandom_range(0, 15);
				col = $urandom_range(0, 15);
			end else begin
				// most traffic on a few handles so frees and lookups hit
				row = $urandom_range(0, (side > 4) ? 3 : side - 1);
				col = $urandom_range(0, side - 1);
			end
			pick = $urandom_range(0, 99);
			if (pick < 5) n = $urandom_range(0, 127);
			else if (pick < 8) n = 0;
			else if (lim == 0) n = $urandom_range(1, 64);
			else if (pick < 80) n = $urandom_range(1, (lim < 16) ? lim : 16);
			else n = $urandom_range(1, lim);
			queue_item(t, row, col, n);
		end
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		for (int i = 0; i < POOL_UNITS; i++) unit_used[i] = 0;
		for (int i = 0; i < HANDLES; i++) begin
			run_start[i] = '0;
			run_len[i] = '0;
		end
		next_hint = '0;
		side_reg = 5'd16;
		limit_reg = 7'd64;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset settings: size checks, empty handles, realloc, full pool
		queue_item(REQ_ALLOC, 0, 0, 0);
		queue_item(REQ_ALLOC, 0, 0, 65);
		queue_item(REQ_ALLOC, 0, 0, 127);
		queue_item(REQ_FREE, 15, 15, 0);
		queue_item(REQ_LOOKUP, 15, 15, 0);
		queue_item(REQ_ODD, 15, 15, 0);
		queue_item(REQ_ALLOC, 15, 15, 1);
		queue_item(REQ_ODD, 15, 15, 0);
		queue_item(REQ_ALLOC, 15, 15, 64);
		for (int i = 0; i < 15; i++) queue_item(REQ_ALLOC, 1, i, 64);
		queue_item(REQ_ALLOC, 2, 0, 1);
		queue_item(REQ_ALLOC, 15, 15, 64);
		queue_item(REQ_FREE, 1, 3, 0);
		queue_item(REQ_ALLOC, 2, 0, 64);
		queue_item(REQ_LOOKUP, 2, 0, 0);
		wait_quiet();

		// grid limits: small side, zero side, oversize side and limit codes
		cfg_write(CFG_SIDE, 7'd3);
		cfg_write(CFG_SPARE, 7'h7F);
		cfg_finish();
		queue_item(REQ_ALLOC, 3, 0, 4);
		queue_item(REQ_LOOKUP, 0, 3, 0);
		queue_item(REQ_ALLOC, 2, 2, 4);
		wait_quiet();
		cfg_write(CFG_SIDE, 7'd0);
		cfg_write(CFG_LIMIT, 7'd0);
		cfg_finish();
		queue_item(REQ_ALLOC, 0, 0, 1);
		queue_item(REQ_LOOKUP, 0, 0, 0);
		wait_quiet();
		cfg_write(CFG_SIDE, 7'h7F);
		cfg_finish();
		queue_item(REQ_ALLOC, 0, 0, 1);
		wait_quiet();
		cfg_write(CFG_LIMIT, 7'h7F);
		cfg_finish();
		queue_item(REQ_ALLOC, 15, 15, 64);
		queue_item(REQ_ALLOC, 15, 14, 65);
		wait_quiet();

		// random phases across several settings
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin cfg_write(CFG_SIDE, 7'd16); cfg_write(CFG_LIMIT, 7'd64); end
				1: begin cfg_write(CFG_SIDE, 7'd1); cfg_write(CFG_LIMIT, 7'd1); end
				2: begin cfg_write(CFG_SIDE, 7'd7); cfg_write(CFG_LIMIT, 7'd20); end
				3: begin cfg_write(CFG_SIDE, 7'd31); cfg_write(CFG_LIMIT, 7'd127); end
				4: begin cfg_write(CFG_SIDE, 7'd0); cfg_write(CFG_LIMIT, 7'd5); end
				5: begin cfg_write(CFG_SIDE, 7'd16); cfg_write(CFG_LIMIT, 7'd8); end
				6: begin cfg_write(CFG_SIDE, 7'd4); cfg_write(CFG_LIMIT, 7'd0); end
				default: begin cfg_write(CFG_SIDE, 7'd16); cfg_write(CFG_LIMIT, 7'd64); end
			endcase
			cfg_finish();
			queue_random((p == 4 || p == 6) ? 40 : 280);
			wait_quiet();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

### bitmap_next_fit_allocator_unit.f
+incdir+rtl
rtl/bnfa_pkg.sv
rtl/bnfa_ctrl.sv
rtl/bnfa_dp.sv
rtl/bitmap_next_fit_allocator_unit.sv
verif/testbench.sv
